@@ src/mbsp_pkg.sv @@
// Shared constants, codes and handshake structs of the MIDI byte stream parser.
package mbsp_pkg;

  localparam int BUF_BYTES = 64;                 // sysex chunk buffer depth
  localparam int BUF_AW    = $clog2(BUF_BYTES);  // buffer address width
  localparam int FILL_W    = BUF_AW + 1;         // fill count, holds BUF_BYTES itself
  localparam int BYTE_W    = 8;
  localparam int TS_W      = 32;
  localparam int CFG_W     = 7;                  // widest register: chunk size
  localparam int CFG_IDX_W = 2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_SYSEX   = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_TIMING  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_IGNORE_SENSING = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE     = 2'd3;

  // MIDI byte codes
  localparam logic [7:0] B_SYSEX_START = 8'hF0;
  localparam logic [7:0] B_MTC         = 8'hF1;
  localparam logic [7:0] B_SONG_POS    = 8'hF2;
  localparam logic [7:0] B_SONG_SEL    = 8'hF3;
  localparam logic [7:0] B_TUNE_REQ    = 8'hF6;
  localparam logic [7:0] B_SYSEX_END   = 8'hF7;
  localparam logic [7:0] B_RT_FIRST    = 8'hF8;
  localparam logic [7:0] B_RT_TIMING   = 8'hFB;  // last timing real-time code
  localparam logic [7:0] B_SENSE       = 8'hFE;
  localparam logic [3:0] HI_NOTE_OFF   = 4'h8;
  localparam logic [3:0] HI_PROG       = 4'hC;
  localparam logic [3:0] HI_PRESS      = 4'hD;
  localparam logic [3:0] HI_BEND       = 4'hE;
  localparam logic [3:0] HI_SYSTEM     = 4'hF;

  localparam logic [CFG_W-1:0] CHUNK_RESET = CFG_W'(BUF_BYTES);

  // controller -> datapath
  typedef struct packed {
    logic capture;   // input beat taken
    logic decode;    // apply one parse step
    logic rd_first;  // fetch first byte of the run
    logic load;      // move one byte into the output register
  } mbsp_cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic emit;      // the step produces a run
    logic out_free;  // output register can take a beat
    logic last;      // byte being loaded ends the run
  } mbsp_sts_t;

endpackage

@@ src/mbsp_in_if.sv @@
// Input channel: one received MIDI byte and its time stamp per beat.
interface mbsp_in_if import mbsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] midi_byte;
  logic [TS_W-1:0]   time_stamp;

  modport source (output valid, output midi_byte, output time_stamp, input ready);
  modport sink   (input valid, input midi_byte, input time_stamp, output ready);
endinterface

@@ src/mbsp_out_if.sv @@
// Result channel: one byte of an emitted message per beat.
interface mbsp_out_if import mbsp_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [BYTE_W-1:0] out_byte;
  logic              end_of_message;
  logic              sysex_continues;
  logic [TS_W-1:0]   msg_time;

  modport source (output valid, output out_byte, output end_of_message,
                  output sysex_continues, output msg_time, input ready);
  modport sink   (input valid, input out_byte, input end_of_message,
                  input sysex_continues, input msg_time, output ready);
endinterface

@@ src/mbsp_datapath.sv @@
// Parser datapath: config registers, parse state, sysex buffer and output register.
module mbsp_datapath import mbsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  input  logic [BYTE_W-1:0]    in_midi_byte,
  input  logic [TS_W-1:0]      in_time_stamp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [BYTE_W-1:0]    out_byte,
  output logic                 out_end_of_message,
  output logic                 out_sysex_continues,
  output logic [TS_W-1:0]      out_msg_time,
  input  mbsp_cmd_t            cmd,
  output mbsp_sts_t            sts
);

  typedef enum logic [1:0] {M_IDLE = 2'd0, M_DATA = 2'd1, M_SYSEX = 2'd2} mode_t;
  typedef enum logic [1:0] {SRC_MEM, SRC_SHORT, SRC_BYTE} src_t;

  function automatic logic [1:0] data_len(input logic [7:0] st);
    logic [3:0] hi;
    hi = st[7:4];
    if (hi == HI_PROG || hi == HI_PRESS || st == B_MTC || st == B_SONG_SEL) begin
      return 2'd1;
    end else if ((hi >= HI_NOTE_OFF && hi <= HI_BEND) || st == B_SONG_POS) begin
      return 2'd2;
    end else begin
      return 2'd0;
    end
  endfunction

  // channel messages always pass; system common only when enabled
  function automatic logic pass_msg(input logic [7:0] st, input logic ign_t,
                                    input logic ign_s);
    if (st[7:4] != HI_SYSTEM) begin
      return 1'b1;
    end else begin
      return (!ign_t && (st == B_MTC || st == B_SONG_SEL)) ||
             (!ign_s && st == B_TUNE_REQ);
    end
  endfunction

  // configuration
  logic             ign_sysex_r, ign_timing_r, ign_sensing_r;
  logic [CFG_W-1:0] chunk_cfg_r;

  // captured beat
  logic [BYTE_W-1:0] byte_r;
  logic [TS_W-1:0]   ts_r;

  // parse state
  mode_t             mode_r, mode_nxt;
  logic [7:0]        rs_r, rs_nxt;
  logic [FILL_W-1:0] fill_r, fill_nxt;
  logic [1:0]        dn_r, dn_nxt;
  logic [7:0]        sb_r [3];
  logic [7:0]        sb_nxt [3];

  // run descriptor
  logic [FILL_W-1:0] run_len_r, run_len_nxt;
  logic              run_cont_r, run_cont_nxt;
  src_t              run_src_r, run_src_nxt;
  logic              emit_go;

  // sysex buffer
  logic [7:0]        mem [BUF_BYTES];
  logic [7:0]        mem_q_r;
  logic              mem_we;
  logic [BUF_AW-1:0] mem_wa;
  logic              rd_en;
  logic [BUF_AW-1:0] rd_addr;

  // decode helpers
  logic              has_room;
  logic [FILL_W-1:0] fill_inc;
  logic [FILL_W-1:0] chunk_eff;
  logic              ds_start;
  logic [7:0]        ds_st;
  logic [1:0]        ds_need;
  logic [FILL_W-1:0] ds_pos;
  logic [FILL_W-1:0] ds_cnt;

  // emission
  logic [FILL_W-1:0] emit_idx_r;
  logic [FILL_W-1:0] idx_inc;
  logic              last;
  logic [7:0]        short_q;
  logic [7:0]        load_byte;

  // output register
  logic              out_valid_r;
  logic [7:0]        out_byte_r;
  logic              out_eom_r;
  logic              out_cont_r;
  logic [TS_W-1:0]   out_time_r;

  assign has_room  = (fill_r < FILL_W'(BUF_BYTES));
  assign fill_inc  = fill_r + FILL_W'(has_room);
  assign chunk_eff = (chunk_cfg_r == '0 || chunk_cfg_r > CFG_W'(BUF_BYTES)) ?
                     FILL_W'(BUF_BYTES) : FILL_W'(chunk_cfg_r);

  // data byte outside sysex: new message under running status or next data byte
  assign ds_start = (mode_r != M_DATA);
  assign ds_st    = ds_start ? rs_r : sb_r[0];
  assign ds_need  = ds_start ? data_len(rs_r) : dn_r;
  assign ds_pos   = ds_start ? FILL_W'(1) : fill_r;
  assign ds_cnt   = ds_pos + FILL_W'(1);

  always_comb begin
    mode_nxt     = mode_r;
    rs_nxt       = rs_r;
    fill_nxt     = fill_r;
    dn_nxt       = dn_r;
    sb_nxt       = sb_r;
    mem_we       = 1'b0;
    mem_wa       = fill_r[BUF_AW-1:0];
    emit_go      = 1'b0;
    run_len_nxt  = run_len_r;
    run_cont_nxt = 1'b0;
    run_src_nxt  = run_src_r;
    if (mode_r == M_SYSEX) begin
      run_src_nxt = SRC_MEM;
      run_len_nxt = fill_inc;
      if (byte_r == B_SYSEX_END) begin
        mem_we   = has_room && !ign_sysex_r;
        emit_go  = !ign_sysex_r;
        mode_nxt = M_IDLE;
        rs_nxt   = '0;
        fill_nxt = '0;
      end else begin
        mem_we = has_room;
        if (fill_inc >= chunk_eff) begin
          emit_go      = !ign_sysex_r;
          run_cont_nxt = 1'b1;
          fill_nxt     = '0;
        end else begin
          fill_nxt = fill_inc;
        end
      end
    end else if (byte_r >= B_RT_FIRST) begin
      // real-time: alone, state untouched
      emit_go     = (!ign_timing_r && byte_r <= B_RT_TIMING) ||
                    (!ign_sensing_r && byte_r >= B_SENSE);
      run_src_nxt = SRC_BYTE;
      run_len_nxt = FILL_W'(1);
    end else if (byte_r[7]) begin
      fill_nxt  = FILL_W'(1);
      sb_nxt[0] = byte_r;
      dn_nxt    = data_len(byte_r);
      mode_nxt  = (data_len(byte_r) != 2'd0) ? M_DATA : M_IDLE;
      if (byte_r == B_SYSEX_START) begin
        mode_nxt = M_SYSEX;
        mem_we   = 1'b1;
        mem_wa   = '0;
      end else if (data_len(byte_r) == 2'd0) begin
        emit_go     = pass_msg(byte_r, ign_timing_r, ign_sensing_r);
        run_src_nxt = SRC_SHORT;
        run_len_nxt = FILL_W'(1);
      end
    end else if (!(ds_start && rs_r == '0)) begin
      if (ds_start) begin
        sb_nxt[0] = rs_r;
        dn_nxt    = ds_need;
        mode_nxt  = M_DATA;
      end
      case (ds_pos[1:0])
        2'd1:    sb_nxt[1] = byte_r;
        2'd2:    sb_nxt[2] = byte_r;
        default: ;
      endcase
      fill_nxt = ds_cnt;
      if (ds_cnt == FILL_W'(ds_need) + FILL_W'(1)) begin
        if (ds_st[7:4] != HI_SYSTEM) rs_nxt = ds_st;
        mode_nxt    = M_IDLE;
        emit_go     = pass_msg(ds_st, ign_timing_r, ign_sensing_r);
        run_src_nxt = SRC_SHORT;
        run_len_nxt = ds_cnt;
      end
    end
  end

  // run readout
  assign idx_inc = emit_idx_r + FILL_W'(1);
  assign last    = (idx_inc == run_len_r);
  assign rd_en   = cmd.rd_first || (cmd.load && !last);
  assign rd_addr = cmd.rd_first ? '0 : idx_inc[BUF_AW-1:0];

  always_comb begin
    case (emit_idx_r[1:0])
      2'd1:    short_q = sb_r[1];
      2'd2:    short_q = sb_r[2];
      default: short_q = sb_r[0];
    endcase
  end

  always_comb begin
    case (run_src_r)
      SRC_MEM:   load_byte = mem_q_r;
      SRC_SHORT: load_byte = short_q;
      default:   load_byte = byte_r;
    endcase
  end

  assign sts.emit     = emit_go;
  assign sts.out_free = !out_valid_r || out_ready;
  assign sts.last     = last;

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ign_sysex_r   <= 1'b1;
      ign_timing_r  <= 1'b1;
      ign_sensing_r <= 1'b1;
      chunk_cfg_r   <= CHUNK_RESET;
      mode_r        <= M_IDLE;
      rs_r          <= '0;
      fill_r        <= '0;
      dn_r          <= '0;
      out_valid_r   <= 1'b0;
    end else begin
      if (cfg_we) begin
        unique case (cfg_index)
          REG_IGNORE_SYSEX:   ign_sysex_r   <= cfg_wdata[0];
          REG_IGNORE_TIMING:  ign_timing_r  <= cfg_wdata[0];
          REG_IGNORE_SENSING: ign_sensing_r <= cfg_wdata[0];
          REG_CHUNK_SIZE:     chunk_cfg_r   <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.decode) begin
        mode_r <= mode_nxt;
        rs_r   <= rs_nxt;
        fill_r <= fill_nxt;
        dn_r   <= dn_nxt;
      end
      if (cmd.load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      byte_r <= in_midi_byte;
      ts_r   <= in_time_stamp;
    end
    if (cmd.decode) begin
      sb_r       <= sb_nxt;
      run_len_r  <= run_len_nxt;
      run_cont_r <= run_cont_nxt;
      run_src_r  <= run_src_nxt;
    end
    if (cmd.rd_first) begin
      emit_idx_r <= '0;
    end else if (cmd.load) begin
      emit_idx_r <= idx_inc;
    end
    if (cmd.load) begin
      out_byte_r <= load_byte;
      out_eom_r  <= last;
      out_cont_r <= run_cont_r;
      out_time_r <= ts_r;
    end
  end

  // sysex buffer: one write, one registered read
  always_ff @(posedge clk) begin
    if (cmd.decode && mem_we) begin
      mem[mem_wa] <= byte_r;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      mem_q_r <= mem[rd_addr];
    end
  end

  assign out_valid           = out_valid_r;
  assign out_byte            = out_byte_r;
  assign out_end_of_message  = out_eom_r;
  assign out_sysex_continues = out_cont_r;
  assign out_msg_time        = out_time_r;

endmodule

@@ src/mbsp_ctrl.sv @@
// Parser controller: sequences accept, decode and run readout.
module mbsp_ctrl import mbsp_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  output logic      in_ready,
  output mbsp_cmd_t cmd,
  input  mbsp_sts_t sts
);

  typedef enum logic [1:0] {S_IDLE, S_DECODE, S_RD, S_LD} state_t;

  state_t state_r, state_nxt;
  logic   in_rdy_r;

  assign cmd.capture  = in_valid && in_rdy_r;
  assign cmd.decode   = (state_r == S_DECODE);
  assign cmd.rd_first = (state_r == S_RD);
  assign cmd.load     = (state_r == S_LD) && sts.out_free;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:   if (cmd.capture) state_nxt = S_DECODE;
      S_DECODE: state_nxt = sts.emit ? S_RD : S_IDLE;
      S_RD:     state_nxt = S_LD;
      S_LD:     if (cmd.load && sts.last) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= S_IDLE;
      in_rdy_r <= 1'b0;
    end else begin
      state_r  <= state_nxt;
      in_rdy_r <= (state_nxt == S_IDLE);
    end
  end

  assign in_ready = in_rdy_r;

endmodule

@@ src/midi_byte_stream_parser.sv @@
// MIDI byte stream parser top level: running status, filters and sysex chunking.
// Throughput: one byte at a time. A beat that yields no result passes only the decode
//   state; one that yields a run also passes the read and load states, the run leaving
//   at one byte per cycle (slower when out stalls), sysex runs through the single read
//   port of the 64-byte buffer. The first result byte is valid from its load onwards.
// Reset (rst_n, synchronous, active low): all ignore bits set, chunk size 64, parser
//   idle with no running status; the sysex buffer is not cleared.
module midi_byte_stream_parser import mbsp_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  // configuration writes, taken whenever cfg_we is high
  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata,
  // received bytes
  mbsp_in_if.sink              in_chan,
  // emitted message bytes
  mbsp_out_if.source           out_chan
);

  mbsp_cmd_t cmd;
  mbsp_sts_t sts;

  // Controller: waits for a beat, runs one decode step, then walks any run it
  // yields into the output register while the sink takes beats.
  mbsp_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_chan.valid),
    .in_ready (in_chan.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // Datapath: parse state, short-message bytes, sysex buffer and the output
  // register. The output register lets a new beat in while the last result
  // byte still waits for the sink.
  mbsp_datapath u_dp (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_we              (cfg_we),
    .cfg_index           (cfg_index),
    .cfg_wdata           (cfg_wdata),
    .in_midi_byte        (in_chan.midi_byte),
    .in_time_stamp       (in_chan.time_stamp),
    .out_valid           (out_chan.valid),
    .out_ready           (out_chan.ready),
    .out_byte            (out_chan.out_byte),
    .out_end_of_message  (out_chan.end_of_message),
    .out_sysex_continues (out_chan.sysex_continues),
    .out_msg_time        (out_chan.msg_time),
    .cmd                 (cmd),
    .sts                 (sts)
  );

endmodule

@@ sim/midi_byte_stream_parser_test.sv @@
// Self-checking testbench for midi_byte_stream_parser: predicts every emitted message beat.
import mbsp_pkg::*;

typedef struct packed {
  logic [BYTE_W-1:0] data;
  logic              eom;
  logic              cont;
  logic [TS_W-1:0]   stamp;
} midi_beat_t;

// Tracks parser state from accepted input beats and checks the emitted message beats.
class midi_msg_tracker;
  typedef enum logic [1:0] {PM_IDLE, PM_DATA, PM_SYSEX} parse_mode_t;

  bit               ign_sysex;
  bit               ign_timing;
  bit               ign_sensing;
  logic [CFG_W-1:0] chunk_cfg;
  parse_mode_t      mode;
  logic [7:0]       run_status;
  logic [7:0]       held[BUF_BYTES];
  int               fill;
  int               need;
  midi_beat_t       msg_bytes_due[$];
  int               mismatches;

  function new();
    ign_sysex   = 1'b1;
    ign_timing  = 1'b1;
    ign_sensing = 1'b1;
    chunk_cfg   = CHUNK_RESET;
    mode        = PM_IDLE;
    run_status  = '0;
    fill        = 0;
    need        = 0;
    mismatches  = 0;
  endfunction

  function void set_register(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    case (idx)
      REG_IGNORE_SYSEX:   ign_sysex   = val[0];
      REG_IGNORE_TIMING:  ign_timing  = val[0];
      REG_IGNORE_SENSING: ign_sensing = val[0];
      REG_CHUNK_SIZE:     chunk_cfg   = val;
      default: ;
    endcase
  endfunction

  // data bytes that follow a status byte
  function int data_count(logic [7:0] st);
    logic [3:0] hi;
    hi = st[7:4];
    if (hi == HI_PROG || hi == HI_PRESS || st == B_MTC || st == B_SONG_SEL) return 1;
    if ((hi >= HI_NOTE_OFF && hi <= HI_BEND) || st == B_SONG_POS) return 2;
    return 0;
  endfunction

  function void store(logic [7:0] b);
    if (fill < BUF_BYTES) begin
      held[fill] = b;
      fill++;
    end
  endfunction

  // appends one expected beat
  function void expect_beat(midi_beat_t beat);
    msg_bytes_due = {msg_bytes_due, beat};
  endfunction

  function void queue_run(bit cont, logic [TS_W-1:0] stamp);
    for (int k = 0; k < fill; k++)
      expect_beat('{held[k], k == fill - 1, cont, stamp});
  endfunction

  // complete message in the buffer; system common passes only if allowed
  function void close_msg(logic [TS_W-1:0] stamp);
    logic [7:0] st;
    st = held[0];
    if (st[7:4] != HI_SYSTEM)
      queue_run(1'b0, stamp);
    else if ((!ign_timing && (st == B_MTC || st == B_SONG_SEL)) ||
             (!ign_sensing && st == B_TUNE_REQ))
      queue_run(1'b0, stamp);
  endfunction

  function void take_byte(logic [7:0] b, logic [TS_W-1:0] stamp);
    int lim;
    if (mode == PM_SYSEX) begin
      if (b == B_SYSEX_END) begin
        if (!ign_sysex) begin
          store(b);
          queue_run(1'b0, stamp);
        end
        mode       = PM_IDLE;
        run_status = '0;
        fill       = 0;
      end else begin
        lim = (chunk_cfg == 0 || chunk_cfg > BUF_BYTES) ? BUF_BYTES : int'(chunk_cfg);
        store(b);
        if (fill >= lim) begin
          if (!ign_sysex) queue_run(1'b1, stamp);
          fill = 0;
        end
      end
    end else if (b >= B_RT_FIRST) begin
      if ((!ign_timing && b <= B_RT_TIMING) || (!ign_sensing && b >= B_SENSE))
        expect_beat('{b, 1'b1, 1'b0, stamp});
    end else if (b[7]) begin
      fill = 0;
      store(b);
      need = data_count(b);
      if (b == B_SYSEX_START) begin
        mode = PM_SYSEX;
      end else if (need > 0) begin
        mode = PM_DATA;
      end else begin
        mode = PM_IDLE;
        close_msg(stamp);
      end
    end else if (mode == PM_DATA || run_status != 0) begin
      if (mode != PM_DATA) begin
        fill = 0;
        store(run_status);
        need = data_count(run_status);
        mode = PM_DATA;
      end
      store(b);
      if (fill == need + 1) begin
        if (held[0][7:4] != HI_SYSTEM) run_status = held[0];
        mode = PM_IDLE;
        close_msg(stamp);
      end
    end
  endfunction

  function void note_fault(string what);
    mismatches++;
    if (mismatches <= 10) $display("mismatch: %s", what);
  endfunction

  function void match_beat(midi_beat_t got);
    midi_beat_t want;
    if (msg_bytes_due.size() == 0) begin
      note_fault($sformatf("byte %02h eom %0b cont %0b time %08h with nothing due",
                           got.data, got.eom, got.cont, got.stamp));
      return;
    end
    want = msg_bytes_due.pop_front();
    if (got !== want)
      note_fault($sformatf("exp %02h/%0b/%0b/%08h got %02h/%0b/%0b/%08h (byte/eom/cont/time)",
                           want.data, want.eom, want.cont, want.stamp,
                           got.data, got.eom, got.cont, got.stamp));
  endfunction
endclass

module midi_byte_stream_parser_test;
  timeunit 1ns;
  timeprecision 1ps;

  // channel and system codes the package does not name
  localparam logic [3:0] HI_NOTE_ON  = 4'h9;
  localparam logic [7:0] NOTE_ON_CH0 = {HI_NOTE_ON, 4'h0};
  localparam logic [7:0] B_UNDEF_F4  = 8'hF4;
  localparam logic [7:0] B_UNDEF_F5  = 8'hF5;
  localparam logic [7:0] B_RT_STOP   = 8'hFC;
  localparam logic [7:0] B_RT_RESET  = 8'hFF;

  localparam int MAX_GAP = 18;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_wdata;
  bit                   calm_links;  // both sides run back to back while set

  mbsp_in_if  in_link();
  mbsp_out_if out_link();

  midi_msg_tracker tracker;

  midi_byte_stream_parser i_dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_chan   (in_link.sink),
    .out_chan  (out_link.source)
  );

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Beats on both channels are observed at the rising edge, where the DUT's
  // registered outputs still hold their pre-edge values.
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_link.valid && out_link.ready)
        tracker.match_beat('{out_link.out_byte, out_link.end_of_message,
                             out_link.sysex_continues, out_link.msg_time});
      if (in_link.valid && in_link.ready)
        tracker.take_byte(in_link.midi_byte, in_link.time_stamp);
    end
  end

  // Result side: random stall ahead of each beat, none in calm stretches.
  initial begin
    int stall;
    out_link.ready = 1'b0;
    wait (rst_n === 1'b1);
    @(negedge clk);
    forever begin
      stall = calm_links ? 0 : $urandom_range(0, MAX_GAP);
      if (stall > 0) begin
        out_link.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_link.ready <= 1'b1;
      do @(posedge clk); while (!out_link.valid);
      @(negedge clk);
    end
  end

  // Time stamps hit both extremes now and then.
  function automatic logic [TS_W-1:0] pick_stamp();
    int r;
    r = $urandom_range(0, 15);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return $urandom;
  endfunction

  // One beat on the input side; entered and left at a falling edge.
  task automatic send_byte(input logic [7:0] b, input logic [TS_W-1:0] stamp);
    int gap;
    gap = calm_links ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      in_link.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_link.valid      <= 1'b1;
    in_link.midi_byte  <= b;
    in_link.time_stamp <= stamp;
    do @(posedge clk); while (!in_link.ready);
    @(negedge clk);
  endtask

  task automatic play(input logic [7:0] seq[$]);
    foreach (seq[i]) send_byte(seq[i], pick_stamp());
  endtask

  // Drain: all predicted beats out, then a wait for a byte that emits nothing.
  task automatic settle();
    in_link.valid <= 1'b0;
    while (tracker.msg_bytes_due.size() != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    tracker.set_register(idx, val);
    @(negedge clk);
  endtask

  // Only called with the parser drained; the write enable is lowered once at the end.
  task automatic apply_setup(input bit sx, input bit tm, input bit se,
                             input logic [CFG_W-1:0] chunk);
    put_reg(REG_IGNORE_SYSEX, CFG_W'(sx));
    put_reg(REG_IGNORE_TIMING, CFG_W'(tm));
    put_reg(REG_IGNORE_SENSING, CFG_W'(se));
    put_reg(REG_CHUNK_SIZE, chunk);
    cfg_we <= 1'b0;
    @(negedge clk);
  endtask

  function automatic logic [7:0] any_channel_status();
    return {4'($urandom_range(HI_NOTE_OFF, HI_BEND)), 4'($urandom_range(0, 15))};
  endfunction

  // Appends one random MIDI sequence: mostly well-formed messages, some
  // broken ones and plain noise.
  function automatic void add_sequence(ref logic [7:0] plan[$]);
    logic [7:0] commons[6];
    logic [7:0] st;
    logic [7:0] v;
    int         kind;
    int         n;
    int         len;
    commons = '{B_MTC, B_SONG_SEL, B_SONG_POS, B_TUNE_REQ, B_UNDEF_F4, B_UNDEF_F5};
    kind    = $urandom_range(0, 99);
    if (kind < 45) begin
      // channel message, repeats often lean on running status
      st = any_channel_status();
      n  = tracker.data_count(st);
      for (int r = $urandom_range(0, 2); r >= 0; r--) begin
        if (plan.size() == 0 || $urandom_range(0, 1)) plan = {plan, st};
        for (int d = 0; d < n; d++) begin
          if ($urandom_range(0, 9) == 0)
            plan = {plan, 8'($urandom_range(B_RT_FIRST, B_RT_RESET))};
          plan = {plan, 8'($urandom_range(0, 127))};
        end
      end
    end else if (kind < 60) begin
      st = commons[$urandom_range(0, 5)];
      plan = {plan, st};
      n = tracker.data_count(st);
      for (int d = 0; d < n; d++) plan = {plan, 8'($urandom_range(0, 127))};
    end else if (kind < 70) begin
      plan = {plan, 8'($urandom_range(B_RT_FIRST, B_RT_RESET))};
    end else if (kind < 85) begin
      // sysex; a few long ones to cross the full buffer, status bytes inside too
      plan = {plan, B_SYSEX_START};
      len = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 140) : $urandom_range(0, 12);
      for (int k = 0; k < len; k++) begin
        if ($urandom_range(0, 6) == 0) begin
          v = 8'($urandom_range(128, 255));
          if (v == B_SYSEX_END) v = B_RT_FIRST;
        end else begin
          v = 8'($urandom_range(0, 127));
        end
        plan = {plan, v};
      end
      if ($urandom_range(0, 9) != 0) plan = {plan, B_SYSEX_END};
    end else if (kind < 93) begin
      // message cut short by whatever follows
      st = any_channel_status();
      plan = {plan, st};
      n = tracker.data_count(st);
      for (int d = 0; d < n - 1; d++) plan = {plan, 8'($urandom_range(0, 127))};
    end else begin
      for (int k = $urandom_range(1, 3); k > 0; k--)
        plan = {plan, 8'($urandom_range(0, 255))};
    end
  endfunction

  initial begin
    logic [7:0]       plan[$];
    logic [CFG_W-1:0] forced_chunk[4];
    logic [CFG_W-1:0] chunk;
    int               rand_items;
    int               phase;
    int               pick;
    bit               sx;
    bit               tm;
    bit               se;

    tracker            = new();
    rst_n              = 1'b0;
    cfg_we             = 1'b0;
    cfg_index          = '0;
    cfg_wdata          = '0;
    calm_links         = 1'b0;
    in_link.valid      = 1'b0;
    in_link.midi_byte  = '0;
    in_link.time_stamp = '0;
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Reset registers: note passes, sensing and the whole sysex are dropped.
    play('{NOTE_ON_CH0, 8'h40, 8'h7F, B_SENSE, B_SYSEX_START, 8'h01, B_SYSEX_END});
    settle();

    // Everything allowed, chunk of 4. Real-time alone, system common filters,
    // dropped song position / undefined / stray end, running status kept across
    // a system common message, sysex with status bytes inside split in two
    // chunks, stray data after sysex (running status cleared), full-scale bend.
    apply_setup(1'b0, 1'b0, 1'b0, CFG_W'(4));
    play('{B_RT_FIRST, B_RT_RESET, B_RT_STOP, B_TUNE_REQ, B_SONG_SEL, 8'h7F,
           B_SONG_POS, 8'h00, 8'h7F, B_UNDEF_F4, B_SYSEX_END,
           {HI_PROG, 4'h5}, 8'h00, B_MTC, 8'h55, 8'h12,
           B_SYSEX_START, 8'h01, 8'h02, B_RT_FIRST, {HI_NOTE_OFF, 4'h0}, B_SYSEX_END,
           8'h33, {HI_BEND, 4'hF}, 8'h7F, 8'h7F});
    settle();

    // Chunk size zero means the full buffer; then lowered mid-sysex, so the
    // next byte flushes an oversized chunk and the end byte goes out alone.
    apply_setup(1'b0, 1'b1, 1'b1, '0);
    play('{B_SYSEX_START, 8'h01, 8'h02, 8'h03, 8'h04});
    settle();
    apply_setup(1'b0, 1'b1, 1'b1, CFG_W'(2));
    play('{8'h05, B_SYSEX_END});
    settle();

    // Random phases, each under its own register setting and idling style.
    forced_chunk = '{CFG_W'(1), CHUNK_RESET, '1, '0};
    rand_items   = 0;
    phase        = 0;
    while (rand_items < 280) begin
      sx = ($urandom_range(0, 3) == 0);
      tm = $urandom_range(0, 1);
      se = $urandom_range(0, 1);
      if (phase < 4) begin
        chunk = forced_chunk[phase];
        if (phase == 0) {sx, tm, se} = 3'b000;
        if (phase == 1) {sx, tm, se} = 3'b111;
      end else begin
        pick = $urandom_range(0, 9);
        if (pick == 0) chunk = '0;
        else if (pick == 1) chunk = '1;
        else if (pick == 2) chunk = CHUNK_RESET;
        else chunk = CFG_W'($urandom_range(1, 24));
      end
      apply_setup(sx, tm, se, chunk);
      calm_links = ($urandom_range(0, 3) == 0);
      plan.delete();
      while (plan.size() < 30) add_sequence(plan);
      play(plan);
      rand_items += plan.size();
      settle();
      phase++;
    end

    calm_links = 1'b0;
    repeat (10) @(posedge clk);
    if (tracker.mismatches == 0 && tracker.msg_bytes_due.size() == 0) begin
      $display("midi_byte_stream_parser_test: clean");
    end else begin
      $display("midi_byte_stream_parser_test: errors");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest legal run of this stimulus.
  initial begin
    #100_000_000;
    $display("midi_byte_stream_parser_test: errors");
    $finish;
  end

endmodule
